@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion helper macro for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on the rising clock edge, off during active-low reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`endif

@@ src/spsl_pkg.sv @@
// ----------------------------------------------------------------------------
// Servo pulse slew limiter package
// Widths, register indexes and action codes shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package spsl_pkg;

  localparam int CountBits = 16;
  localparam int CmpBits   = (CountBits > 16) ? CountBits : 16;
  localparam int PosBits   = 17;
  localparam int AddrBits  = 4;
  localparam int DataBits  = 32;

  typedef logic [CountBits-1:0] level_t;

  typedef enum logic [1:0] {
    ActSetNow   = 2'd0,
    ActSetTrack = 2'd1,
    ActTick     = 2'd2,
    ActNone     = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    RegMinCount    = 2'd0,
    RegMaxCount    = 2'd1,
    RegLongestMax  = 2'd2,
    RegMaxStep     = 2'd3
  } reg_idx_e;

  localparam logic [15:0] MinCountRst = 16'd3205;
  localparam logic [15:0] MaxCountRst = 16'd6410;
  localparam logic [15:0] MaxStepRst  = 16'd30;

endpackage

`default_nettype wire

@@ src/servo_pulse_slew_limiter.sv @@
// Path: an accepted input goes to the input register, then the result register.
// Throughput: one item per cycle while out_stall_i is low; the level update
// is one pass of multiply-add and slew compare between the two registers.
// Reset: asynchronous, active low; levels clear to 0, registers load their
// defaults, both pipeline stages empty.
// ----------------------------------------------------------------------------
// Servo pulse slew limiter
// Maps a Q1.16 position (saturated at 1.0) to a PWM compare level and slews
// the current level toward the target by at most max_step on each period tick, or sets it on a set-now action.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module servo_pulse_slew_limiter
  import spsl_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [1:0]          action_i,
  input  wire logic [PosBits-1:0]  position_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [15:0]              pulse_level_o,
  output logic                     at_target_o,
  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [AddrBits-1:0] paddr,
  input  wire logic [DataBits-1:0] pwdata,
  output logic [DataBits-1:0]      prdata,
  output logic                     pready
);

  logic [15:0] min_count_q, max_count_q, max_step_q;
  logic        longest_max_q;
  logic        cfg_wr;
  reg_idx_e    cfg_idx;

  level_t      target_q, target_d, current_q, current_d;

  logic               pipe_valid_q;
  action_e            pipe_action_q;
  logic [PosBits-1:0] pipe_pos_q;
  logic               advance, in_accept;

  logic               out_valid_q;
  logic [15:0]        level_out_q;
  logic               at_target_q;

  logic [16:0]        pos_sat, pos_eff;
  logic [15:0]        span;
  logic [33:0]        product;
  logic [15:0]        scaled;
  level_t             new_level;
  level_t             diff;
  logic [CmpBits-1:0] diff_w, step_w, delta_w;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_e'(paddr[3:2]);

  always_comb begin
    prdata = '0;
    case (cfg_idx)
      RegMinCount:   prdata = DataBits'(min_count_q);
      RegMaxCount:   prdata = DataBits'(max_count_q);
      RegLongestMax: prdata = DataBits'(longest_max_q);
      RegMaxStep:    prdata = DataBits'(max_step_q);
      default:       prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      min_count_q   <= MinCountRst;
      max_count_q   <= MaxCountRst;
      longest_max_q <= 1'b1;
      max_step_q    <= MaxStepRst;
    end else if (cfg_wr) begin
      case (cfg_idx)
        RegMinCount:   min_count_q   <= pwdata[15:0];
        RegMaxCount:   max_count_q   <= pwdata[15:0];
        RegLongestMax: longest_max_q <= pwdata[0];
        RegMaxStep:    max_step_q    <= pwdata[15:0];
        default:       ;
      endcase
    end
  end

  // Pipeline control
  assign advance    = !out_valid_q || !out_stall_i;
  assign in_stall_o = pipe_valid_q && !advance;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pipe_valid_q <= 1'b0;
    end else if (!pipe_valid_q || advance) begin
      pipe_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      pipe_action_q <= action_e'(action_i);
      pipe_pos_q    <= position_i;
    end
  end

  // Position to level
  always_comb begin
    pos_sat   = pipe_pos_q[16] ? 17'h10000 : 17'(pipe_pos_q[15:0]);
    pos_eff   = longest_max_q ? pos_sat : (17'h10000 - pos_sat);
    span      = (max_count_q > min_count_q) ? (max_count_q - min_count_q) : 16'd0;
    product   = 34'(pos_eff) * 34'(span) + 34'd32768;
    scaled    = product[31:16];
    new_level = level_t'(min_count_q) + level_t'(scaled);
  end

  // Slew toward target
  always_comb begin
    diff     = (target_q > current_q) ? (target_q - current_q) : (current_q - target_q);
    diff_w   = CmpBits'(diff);
    step_w   = CmpBits'(max_step_q);
    delta_w  = (diff_w < step_w) ? diff_w : step_w;
    target_d  = target_q;
    current_d = current_q;
    case (pipe_action_q)
      ActSetNow: begin
        target_d  = new_level;
        current_d = new_level;
      end
      ActSetTrack: begin
        target_d = new_level;
      end
      ActTick: begin
        if (target_q > current_q) begin
          current_d = current_q + level_t'(delta_w);
        end else if (target_q < current_q) begin
          current_d = current_q - level_t'(delta_w);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q    <= '0;
      current_q   <= '0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= pipe_valid_q;
      if (pipe_valid_q) begin
        target_q  <= target_d;
        current_q <= current_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance && pipe_valid_q) begin
      level_out_q <= 16'(current_d);
      at_target_q <= (current_d == target_d);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign pulse_level_o = level_out_q;
  assign at_target_o   = at_target_q;

  `ASSERT_CLK(a_stall_needs_item, clk_i, rst_ni, in_stall_o |-> pipe_valid_q)
  `ASSERT_CLK(a_drain_empties, clk_i, rst_ni,
    (out_valid_q && !out_stall_i && !pipe_valid_q) |=> !out_valid_o)
  `ASSERT_CLK(a_at_target_match, clk_i, rst_ni,
    (advance && pipe_valid_q) |=> (at_target_q == (current_q == target_q)))
  `ASSERT_CLK(a_set_now_aligns, clk_i, rst_ni,
    (advance && pipe_valid_q && pipe_action_q == ActSetNow) |=> (current_q == target_q))

endmodule

`default_nettype wire
